// ===== design/esfd_pkg.sv =====
// ----------------------------------------------------------------------------
// esfd_pkg: shared constants, types and tables for the seconds-to-FAT converter
// Division constants, reciprocal multipliers and the month base table.
// ----------------------------------------------------------------------------
package esfd_pkg;

  // calendar and clock constants
  localparam int unsigned MsPerSec    = 1000;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaySkip     = 47541;  // day index of the dropped 2100 leap day
  localparam int unsigned DayBias     = 2255;
  localparam int unsigned CentBias    = 12210;
  localparam int unsigned CentScale   = 100;
  localparam int unsigned DaysPerCent = 36525;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned MonthDiv    = 10000;
  localparam int unsigned MonthScale  = 306001;
  localparam int unsigned YearBase    = 1965;
  localparam int unsigned FatYearBase = 1980;
  localparam int unsigned OffsetReset = 7200;

  // Reciprocal multipliers: q = (x * ceil(2^k / d)) >> k is exact while x * err < 2^k.
  // ms / 1000 = (ms >> 3) / 125, x < 2^29
  localparam int unsigned MsShift  = 36;
  localparam logic [63:0] MsMag64  =
    ((64'd1 << MsShift) + 64'(MsPerSec / 8) - 64'd1) / 64'(MsPerSec / 8);
  localparam logic [29:0] MsMagic  = MsMag64[29:0];

  // t / 86400 = (t >> 7) / 675, x < 2^25
  localparam int unsigned DayShift = 35;
  localparam logic [63:0] DayMag64 =
    ((64'd1 << DayShift) + 64'(SecsPerDay / 128) - 64'd1) / 64'(SecsPerDay / 128);
  localparam logic [25:0] DayMagic = DayMag64[25:0];

  // sod / 3600 = (sod >> 4) / 225, x < 2^13
  localparam int unsigned HourShift = 21;
  localparam logic [63:0] HourMag64 =
    ((64'd1 << HourShift) + 64'(SecsPerHour / 16) - 64'd1) / 64'(SecsPerHour / 16);
  localparam logic [13:0] HourMagic = HourMag64[13:0];

  // rem / 60 = (rem >> 2) / 15, x < 2^10
  localparam int unsigned MinShift = 14;
  localparam logic [63:0] MinMag64 =
    ((64'd1 << MinShift) + 64'(SecsPerMin / 4) - 64'd1) / 64'(SecsPerMin / 4);
  localparam logic [10:0] MinMagic = MinMag64[10:0];

  // century term / 36525, x < 2^23
  localparam int unsigned CentShift = 39;
  localparam logic [63:0] CentMag64 =
    ((64'd1 << CentShift) + 64'(DaysPerCent) - 64'd1) / 64'(DaysPerCent);
  localparam logic [23:0] CentMagic = CentMag64[23:0];

  // month term / 306001, x < 2^23
  localparam int unsigned MonShift = 42;
  localparam logic [63:0] MonMag64 =
    ((64'd1 << MonShift) + 64'(MonthScale) - 64'd1) / 64'(MonthScale);
  localparam logic [23:0] MonMagic = MonMag64[23:0];

  // pipeline depths of the two result lanes
  localparam int unsigned DateStages = 9;
  localparam int unsigned TodStages  = 4;
  localparam int unsigned TodPad     = DateStages - TodStages;

  typedef struct packed {
    logic        vld;
    logic [15:0] days;
    logic [16:0] sod;
  } split_t;

  // floor(e * 30.6001): days before month e of the shifted year
  function automatic logic [8:0] month_base(input logic [3:0] e);
    logic [8:0] f;
    unique case (e)
      4'd0:  f = 9'd0;
      4'd1:  f = 9'd30;
      4'd2:  f = 9'd61;
      4'd3:  f = 9'd91;
      4'd4:  f = 9'd122;
      4'd5:  f = 9'd153;
      4'd6:  f = 9'd183;
      4'd7:  f = 9'd214;
      4'd8:  f = 9'd244;
      4'd9:  f = 9'd275;
      4'd10: f = 9'd306;
      4'd11: f = 9'd336;
      4'd12: f = 9'd367;
      4'd13: f = 9'd397;
      4'd14: f = 9'd428;
      4'd15: f = 9'd459;
    endcase
    return f;
  endfunction

endpackage

// ===== design/esfd_split.sv =====
// ----------------------------------------------------------------------------
// esfd_split: local seconds and day split
// Forms synced + offset + ms/1000 and splits it into day count and second of day.
// ----------------------------------------------------------------------------
module esfd_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [31:0]          synced_seconds,
  input  logic [31:0]          elapsed_ms,
  input  logic signed [16:0]   offset,
  output esfd_pkg::split_t     split
);
  import esfd_pkg::*;

  logic        v1, v2, v3, v4;
  logic [31:0] synced1;
  logic [58:0] ms_prod;
  logic [31:0] t2, t3;
  logic [50:0] day_prod;
  logic [15:0] days4;
  logic [16:0] sod4;

  logic [22:0] ms_sec;
  logic [31:0] offset32;
  logic [31:0] t_sum;
  logic [15:0] days_w;
  logic [31:0] day_base;

  assign ms_sec   = ms_prod[58:MsShift];
  assign offset32 = {{15{offset[16]}}, offset};
  assign t_sum    = synced1 + offset32 + {9'd0, ms_sec};
  assign days_w   = day_prod[50:DayShift];
  assign day_base = 32'(days_w) * 32'(SecsPerDay);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      synced1  <= synced_seconds;
      ms_prod  <= elapsed_ms[31:3] * MsMagic;
      t2       <= t_sum;
      t3       <= t2;
      day_prod <= t2[31:7] * DayMagic;
      days4    <= days_w;
      sod4     <= 17'(t3 - day_base);
    end
  end

  assign split.vld  = v4;
  assign split.days = days4;
  assign split.sod  = sod4;

endmodule

// ===== design/esfd_tod.sv =====
// ----------------------------------------------------------------------------
// esfd_tod: time of day
// Hour, minute and second from the second of day, delayed to meet the date lane.
// ----------------------------------------------------------------------------
module esfd_tod (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] sod,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);
  import esfd_pkg::*;

  logic [16:0] sod1;
  logic [26:0] hour_prod;
  logic [4:0]  hour2, hour3, hour4;
  logic [11:0] rem2, rem3;
  logic [20:0] min_prod;
  logic [5:0]  minute4, second4;
  logic [16:0] pad [TodPad];

  logic [4:0]  hour_w;
  logic [16:0] hour_base;
  logic [5:0]  minute_w;
  logic [11:0] min_base;

  assign hour_w    = hour_prod[HourShift+4:HourShift];
  assign hour_base = 17'(hour_w) * 17'(SecsPerHour);
  assign minute_w  = min_prod[MinShift+5:MinShift];
  assign min_base  = 12'(minute_w) * 12'(SecsPerMin);

  always_ff @(posedge clk) begin
    if (en) begin
      sod1      <= sod;
      hour_prod <= sod[16:4] * HourMagic;
      hour2     <= hour_w;
      rem2      <= 12'(sod1 - hour_base);
      hour3     <= hour2;
      rem3      <= rem2;
      min_prod  <= rem2[11:2] * MinMagic;
      hour4     <= hour3;
      minute4   <= minute_w;
      second4   <= 6'(rem3 - min_base);
      pad[0]    <= {hour4, minute4, second4};
      for (int i = 1; i < TodPad; i++) begin
        pad[i] <= pad[i-1];
      end
    end
  end

  assign {hour, minute, second} = pad[TodPad-1];

endmodule

// ===== design/esfd_date.sv =====
// ----------------------------------------------------------------------------
// esfd_date: calendar date
// Year, month and day from the day count, skipping the 2100 leap day.
// ----------------------------------------------------------------------------
module esfd_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [15:0] days,
  output logic        vld,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);
  import esfd_pkg::*;

  logic [DateStages-1:0] v;

  logic [15:0] b1, b2, b3, b4;
  logic [22:0] cnum2;
  logic [46:0] cent_prod;
  logic [7:0]  c4, c5, c6, c7, c8;
  logic [8:0]  r5, r6, r7, r8;
  logic [22:0] x6;
  logic [46:0] mon_prod;
  logic [3:0]  e8;
  logic [11:0] year9;
  logic [3:0]  month9;
  logic [4:0]  day9;

  logic [16:0] d_w;
  logic [8:0]  f_w;
  logic [3:0]  month_w;

  assign d_w     = 17'(c4) * 17'(DaysPerYear) + 17'(c4[7:2]);
  assign f_w     = month_base(e8);
  assign month_w = (e8 >= 4'd14) ? e8 - 4'd13 : e8 - 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DateStages-2:0], in_vld};
    end
    if (en) begin
      b1        <= days + 16'(days >= 16'(DaySkip)) + 16'(DayBias);
      b2        <= b1;
      cnum2     <= 23'(b1) * 23'(CentScale) - 23'(CentBias);
      b3        <= b2;
      cent_prod <= cnum2 * CentMagic;
      b4        <= b3;
      c4        <= cent_prod[CentShift+7:CentShift];
      c5        <= c4;
      r5        <= 9'({1'b0, b4} - d_w);
      c6        <= c5;
      r6        <= r5;
      x6        <= 23'(r5) * 23'(MonthDiv);
      c7        <= c6;
      r7        <= r6;
      mon_prod  <= x6 * MonMagic;
      c8        <= c7;
      r8        <= r7;
      e8        <= mon_prod[MonShift+3:MonShift];
      day9      <= 5'(r8 - f_w);
      month9    <= month_w;
      // shifted year runs March to February
      year9     <= 12'(c8) + 12'(YearBase) - 12'(month_w > 4'd2);
    end
  end

  assign vld   = v[DateStages-1];
  assign year  = year9;
  assign month = month9;
  assign day   = day9;

endmodule

// ===== design/epoch_seconds_to_fat_datetime.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_fat_datetime: Unix seconds to local calendar and FAT words
// Pipelined conversion of a synced seconds count plus elapsed milliseconds.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid / cfg_ready  time_offset_seconds
//  in        in         in_valid / in_stall    synced_seconds, elapsed_ms
//  out       out        out_valid / out_stall  packed_date, packed_time, year, month,
//                                              day_of_month, hour, minute, second
//
//  One transaction per cycle while out_stall does not freeze the pipe; stages: 4 split, 9 date, 1 output reg.
//  The depth is set by the date lane's two reciprocal divides and the multiplies
//  that feed them.
//  Reset clears all valid bits and loads the offset with 7200.
//  out_stall with a waiting result freezes the whole pipe and raises in_stall.
// ----------------------------------------------------------------------------
module epoch_seconds_to_fat_datetime (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic signed [16:0]  time_offset_seconds,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         synced_seconds,
  input  logic [31:0]         elapsed_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         packed_date,
  output logic [15:0]         packed_time,
  output logic [11:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day_of_month,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second
);
  import esfd_pkg::*;

  logic signed [16:0] offset;
  logic               en;
  split_t             split;
  logic               date_vld;
  logic [11:0]        date_year;
  logic [3:0]         date_month;
  logic [4:0]         date_day;
  logic [4:0]         tod_hour;
  logic [5:0]         tod_minute;
  logic [5:0]         tod_second;
  logic [11:0]        fat_year;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= 17'(OffsetReset);
    end else if (cfg_valid && cfg_ready) begin
      offset <= time_offset_seconds;
    end
  end

  esfd_split u_split (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_vld         (in_valid),
    .synced_seconds (synced_seconds),
    .elapsed_ms     (elapsed_ms),
    .offset         (offset),
    .split          (split)
  );

  esfd_date u_date (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (split.vld),
    .days   (split.days),
    .vld    (date_vld),
    .year   (date_year),
    .month  (date_month),
    .day    (date_day)
  );

  esfd_tod u_tod (
    .clk    (clk),
    .en     (en),
    .sod    (split.sod),
    .hour   (tod_hour),
    .minute (tod_minute),
    .second (tod_second)
  );

  // FAT year field is (year - 1980) mod 128
  assign fat_year = date_year - 12'(FatYearBase);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= date_vld;
    end
    if (en) begin
      packed_date  <= {fat_year[6:0], date_month, date_day};
      packed_time  <= {tod_hour, tod_minute, tod_second[5:1]};
      year         <= date_year;
      month        <= date_month;
      day_of_month <= date_day;
      hour         <= tod_hour;
      minute       <= tod_minute;
      second       <= tod_second;
    end
  end

`ifndef SYNTHESIS
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0))
    else $error("month or day out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (year >= 12'd1970) && (year <= 12'd2106))
    else $error("year out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
`endif

endmodule
